FILE: rtl/rcs_pkg.sv
`timescale 1ns / 1ps
package rcs_pkg;

  localparam int FRAC_BITS = 12;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int IN_W      = 16;
  localparam int OUT_W     = 18;
  localparam int COEF_W    = 22;
  localparam int PROD_W    = COEF_W + IN_W;
  localparam int T_W       = PROD_W + 2;
  localparam int N_W       = T_W + FRAC_BITS;
  localparam int D_W       = T_W;
  localparam int A_W       = N_W + 3;
  localparam int U_W       = A_W - 1;
  localparam int B_W       = D_W + 1;
  localparam int QB        = (FRAC_BITS + 1 > OUT_W - 1) ? FRAC_BITS + 1 : OUT_W - 1;
  localparam int Q_W       = QB + 1;
  localparam int C_W       = (U_W > B_W + QB) ? U_W : B_W + QB;
  localparam int F_W       = Q_W + 1;
  localparam int DIV_LAT   = QB + 1;
  localparam int MIL       = 1000000;

  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  localparam logic [2:0] SPACE_RGB = 3'd0;
  localparam logic [2:0] SPACE_HSL = 3'd1;
  localparam logic [2:0] SPACE_HSV = 3'd2;
  localparam logic [2:0] SPACE_XYZ = 3'd3;
  localparam logic [2:0] SPACE_YIQ = 3'd4;
  localparam logic [2:0] SPACE_XYY = 3'd5;

  localparam int XYZ_COEF [0:2][0:2] = '{
    '{412453, 357580, 180423},
    '{212671, 715160, 72169},
    '{19334, 119193, 950227}
  };
  localparam int YIQ_COEF [0:2][0:2] = '{
    '{299000, 587000, 114000},
    '{596000, -275000, -321000},
    '{212000, -523000, 311000}
  };
  // column sums of the xyz matrix, for the xyy denominator
  localparam int XYZ_COLSUM [0:2] = '{644458, 1191933, 1202819};

  typedef struct packed {
    logic                    use_div;
    logic                    hue_fix;
    logic                    sat_max;
    logic signed [OUT_W-1:0] direct;
  } lane_ctl_t;

  typedef struct packed {
    logic                  valid;
    logic                  hue_undef;
    lane_ctl_t [2:0]       ctl;
  } side_t;

  typedef struct packed {
    logic signed [N_W-1:0] num;
    logic signed [D_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                  ovf;
    logic signed [Q_W-1:0] quo;
  } div_res_t;

endpackage

FILE: rtl/rcs_div.sv
`timescale 1ns / 1ps
module rcs_div (
  input  logic              clk,
  input  logic              adv,
  input  rcs_pkg::div_req_t req,
  output rcs_pkg::div_res_t res
);

  localparam int A_W = rcs_pkg::A_W;
  localparam int U_W = rcs_pkg::U_W;
  localparam int B_W = rcs_pkg::B_W;
  localparam int C_W = rcs_pkg::C_W;
  localparam int QB  = rcs_pkg::QB;
  localparam int Q_W = rcs_pkg::Q_W;

  logic                  dneg;
  logic signed [A_W-1:0] nn, dd, a;
  logic [U_W-1:0]        u;
  logic [B_W-1:0]        b;
  logic                  pre_ovf;

  logic [U_W-1:0] rem  [0:QB];
  logic [B_W-1:0] bs   [0:QB];
  logic [QB-1:0]  quo  [0:QB];
  logic           neg  [0:QB];
  logic           ovf  [0:QB];
  logic           bz   [0:QB];
  logic [C_W-1:0] trial [1:QB];
  logic           ge    [1:QB];

  // make the divisor positive, then floor((2n+d)/(2d))
  always_comb begin
    dneg    = req.den[rcs_pkg::D_W-1];
    nn      = dneg ? -A_W'(req.num) : A_W'(req.num);
    dd      = dneg ? -A_W'(req.den) : A_W'(req.den);
    a       = (nn <<< 1) + dd;
    u       = a[A_W-1] ? ~a[U_W-1:0] : a[U_W-1:0];
    b       = {dd[B_W-2:0], 1'b0};
    pre_ovf = C_W'(u) >= (C_W'(b) << QB);
  end

  always_comb begin
    for (int k = 1; k <= QB; k++) begin
      trial[k] = C_W'(bs[k-1]) << (QB - k);
      ge[k]    = C_W'(rem[k-1]) >= trial[k];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem[0] <= u;
      bs[0]  <= b;
      quo[0] <= '0;
      neg[0] <= a[A_W-1];
      ovf[0] <= pre_ovf;
      bz[0]  <= (b == '0);
      for (int k = 1; k <= QB; k++) begin
        rem[k] <= ge[k] ? rem[k-1] - trial[k][U_W-1:0] : rem[k-1];
        bs[k]  <= bs[k-1];
        quo[k] <= {quo[k-1][QB-2:0], ge[k]};
        neg[k] <= neg[k-1];
        ovf[k] <= ovf[k-1];
        bz[k]  <= bz[k-1];
      end
    end
  end

  always_comb begin
    res.ovf = 1'b0;
    if (bz[QB]) begin
      res.quo = '0;
    end else if (ovf[QB]) begin
      res.ovf = 1'b1;
      res.quo = neg[QB] ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
    end else begin
      res.quo = neg[QB] ? ~{1'b0, quo[QB]} : {1'b0, quo[QB]};
    end
  end

endmodule

FILE: rtl/rcs_front.sv
`timescale 1ns / 1ps
module rcs_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 adv,
  input  logic                                 in_valid,
  input  logic signed [rcs_pkg::IN_W-1:0]      red,
  input  logic signed [rcs_pkg::IN_W-1:0]      green,
  input  logic signed [rcs_pkg::IN_W-1:0]      blue,
  input  logic [2:0]                           space,
  output rcs_pkg::side_t                       side,
  output rcs_pkg::div_req_t [2:0]              req
);

  localparam int IN_W   = rcs_pkg::IN_W;
  localparam int OUT_W  = rcs_pkg::OUT_W;
  localparam int COEF_W = rcs_pkg::COEF_W;
  localparam int PROD_W = rcs_pkg::PROD_W;
  localparam int T_W    = rcs_pkg::T_W;
  localparam int N_W    = rcs_pkg::N_W;
  localparam int D_W    = rcs_pkg::D_W;
  localparam int FB     = rcs_pkg::FRAC_BITS;

  // stage a
  logic                   va;
  logic [2:0]             space_a;
  logic signed [IN_W-1:0] ca [3];

  // stage b
  logic                     vb;
  logic [2:0]               space_b;
  logic signed [IN_W-1:0]   cb [3];
  logic signed [IN_W-1:0]   mx_b;
  logic [IN_W:0]            d_b;
  logic signed [IN_W:0]     s_b;
  logic signed [PROD_W-1:0] prod_b [3][3];
  logic signed [PROD_W-1:0] col_b [3];

  logic signed [IN_W-1:0]   mx, mn;
  logic signed [COEF_W-1:0] coef [3][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (adv) begin
      va <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      space_a <= space;
      ca[0]   <= red;
      ca[1]   <= green;
      ca[2]   <= blue;
    end
  end

  always_comb begin
    mx = (ca[0] > ca[1]) ? ca[0] : ca[1];
    if (ca[2] > mx) mx = ca[2];
    mn = (ca[0] < ca[1]) ? ca[0] : ca[1];
    if (ca[2] < mn) mn = ca[2];
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        coef[k][j] = (space_a == rcs_pkg::SPACE_YIQ) ? COEF_W'(rcs_pkg::YIQ_COEF[k][j])
                                                      : COEF_W'(rcs_pkg::XYZ_COEF[k][j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (adv) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      space_b <= space_a;
      mx_b    <= mx;
      d_b     <= unsigned'((IN_W+1)'(mx) - (IN_W+1)'(mn));
      s_b     <= (IN_W+1)'(mx) + (IN_W+1)'(mn);
      for (int k = 0; k < 3; k++) begin
        cb[k]    <= ca[k];
        col_b[k] <= PROD_W'(COEF_W'(rcs_pkg::XYZ_COLSUM[k])) * PROD_W'(ca[k]);
        for (int j = 0; j < 3; j++) begin
          prod_b[k][j] <= PROD_W'(coef[k][j]) * PROD_W'(ca[j]);
        end
      end
    end
  end

  // stage c: row sums and lane set-up
  logic signed [T_W-1:0]    t [3];
  logic signed [T_W-1:0]    tsum;
  logic signed [IN_W+1:0]   dsx;
  logic signed [IN_W+3:0]   hn;
  logic signed [D_W-1:0]    sw, den_l;
  logic signed [N_W-1:0]    hue_num, d_num;
  logic signed [D_W-1:0]    hue_den;
  logic signed [IN_W+1:0]   s_inc;
  rcs_pkg::side_t           side_n;
  rcs_pkg::div_req_t [2:0]  req_n;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      t[k] = T_W'(prod_b[k][0]) + T_W'(prod_b[k][1]) + T_W'(prod_b[k][2]);
    end
    tsum = T_W'(col_b[0]) + T_W'(col_b[1]) + T_W'(col_b[2]);
    dsx  = signed'({1'b0, d_b});
    if (cb[0] == mx_b) begin
      hn = (IN_W+4)'(cb[1]) - (IN_W+4)'(cb[2]);
    end else if (cb[1] == mx_b) begin
      hn = ((IN_W+4)'(dsx) <<< 1) + (IN_W+4)'(cb[2]) - (IN_W+4)'(cb[0]);
    end else begin
      hn = ((IN_W+4)'(dsx) <<< 2) + (IN_W+4)'(cb[0]) - (IN_W+4)'(cb[1]);
    end
    hue_num = N_W'(hn) <<< FB;
    hue_den = (D_W'(dsx) <<< 2) + (D_W'(dsx) <<< 1);
    d_num   = N_W'(dsx) <<< FB;
    sw      = D_W'(s_b);
    den_l   = (sw < D_W'(rcs_pkg::ONE)) ? sw : (D_W'(rcs_pkg::ONE) <<< 1) - sw;
    s_inc   = (IN_W+2)'(s_b) + (IN_W+2)'(1);

    side_n.valid     = vb;
    side_n.hue_undef = 1'b0;
    for (int k = 0; k < 3; k++) begin
      side_n.ctl[k] = '0;
      req_n[k]      = '0;
    end

    case (space_b)
      rcs_pkg::SPACE_RGB: begin
        for (int k = 0; k < 3; k++) side_n.ctl[k].direct = OUT_W'(cb[k]);
      end
      rcs_pkg::SPACE_HSL: begin
        side_n.ctl[2].direct = OUT_W'(s_inc >>> 1);
        if (d_b == '0) begin
          side_n.hue_undef = 1'b1;
        end else begin
          if (den_l == '0) begin
            side_n.ctl[1].direct  = rcs_pkg::OUT_MAX;
            side_n.ctl[1].sat_max = 1'b1;
          end else begin
            side_n.ctl[1].use_div = 1'b1;
            req_n[1].num = d_num;
            req_n[1].den = den_l;
          end
          side_n.ctl[0].use_div = 1'b1;
          side_n.ctl[0].hue_fix = 1'b1;
          req_n[0].num = hue_num;
          req_n[0].den = hue_den;
        end
      end
      rcs_pkg::SPACE_HSV: begin
        side_n.ctl[2].direct = OUT_W'(mx_b);
        if (mx_b == '0 || d_b == '0) begin
          side_n.hue_undef = 1'b1;
        end else begin
          side_n.ctl[1].use_div = 1'b1;
          req_n[1].num = d_num;
          req_n[1].den = D_W'(mx_b);
          side_n.ctl[0].use_div = 1'b1;
          side_n.ctl[0].hue_fix = 1'b1;
          req_n[0].num = hue_num;
          req_n[0].den = hue_den;
        end
      end
      rcs_pkg::SPACE_XYZ, rcs_pkg::SPACE_YIQ: begin
        for (int k = 0; k < 3; k++) begin
          side_n.ctl[k].use_div = 1'b1;
          req_n[k].num = N_W'(t[k]);
          req_n[k].den = D_W'(rcs_pkg::MIL);
        end
      end
      rcs_pkg::SPACE_XYY: begin
        if (tsum != '0) begin
          for (int k = 0; k < 3; k++) side_n.ctl[k].use_div = 1'b1;
          req_n[0].num = N_W'(t[0]) <<< FB;
          req_n[0].den = D_W'(tsum);
          req_n[1].num = N_W'(t[1]) <<< FB;
          req_n[1].den = D_W'(tsum);
          req_n[2].num = N_W'(t[1]);
          req_n[2].den = D_W'(rcs_pkg::MIL);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side.valid <= 1'b0;
    end else if (adv) begin
      side.valid <= side_n.valid;
    end
    if (adv) begin
      side.hue_undef <= side_n.hue_undef;
      side.ctl       <= side_n.ctl;
      req            <= req_n;
    end
  end

endmodule

FILE: rtl/rgb_to_color_space.sv
`timescale 1ns / 1ps
// channel   signals                                   direction
// pixel     pixel_valid pixel_ready red green blue    in
// result    result_valid result_ready first_out       out
//           second_out third_out hue_undefined overflowed
// config    cfg_we cfg_data (target_space)            in
//
// one pixel per clock sustained while results are taken; a result is offered once its pixel has passed
// the stages in order (three front stages, a divider set-up stage and one stage per quotient bit, output register)
// the quotient pipeline sets the depth: 4 + max(FRAC_BITS + 2, 18) registers in all
// reset clears the valid bits and selects the rgb copy
// a waiting result freezes every stage; pixel_ready follows it
module rgb_to_color_space (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [2:0]                          cfg_data,
  input  logic                                pixel_valid,
  output logic                                pixel_ready,
  input  logic signed [rcs_pkg::IN_W-1:0]     red,
  input  logic signed [rcs_pkg::IN_W-1:0]     green,
  input  logic signed [rcs_pkg::IN_W-1:0]     blue,
  output logic                                result_valid,
  input  logic                                result_ready,
  output logic signed [rcs_pkg::OUT_W-1:0]    first_out,
  output logic signed [rcs_pkg::OUT_W-1:0]    second_out,
  output logic signed [rcs_pkg::OUT_W-1:0]    third_out,
  output logic                                hue_undefined,
  output logic                                overflowed
);

  localparam int OUT_W   = rcs_pkg::OUT_W;
  localparam int F_W     = rcs_pkg::F_W;
  localparam int DIV_LAT = rcs_pkg::DIV_LAT;

  logic                    adv;
  logic [2:0]              target_space;
  rcs_pkg::side_t          side_c;
  rcs_pkg::div_req_t [2:0] req_c;
  rcs_pkg::div_res_t [2:0] res;
  rcs_pkg::side_t          side_q [DIV_LAT];

  logic signed [F_W-1:0]   v [3];
  logic signed [OUT_W-1:0] val [3];
  logic [2:0]              lane_ovf;

  assign adv         = !result_valid || result_ready;
  assign pixel_ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_space <= rcs_pkg::SPACE_RGB;
    end else if (cfg_we) begin
      target_space <= cfg_data;
    end
  end

  rcs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (pixel_valid),
    .red      (red),
    .green    (green),
    .blue     (blue),
    .space    (target_space),
    .side     (side_c),
    .req      (req_c)
  );

  for (genvar k = 0; k < 3; k++) begin : g_div
    rcs_div u_div (
      .clk (clk),
      .adv (adv),
      .req (req_c[k]),
      .res (res[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIV_LAT; k++) side_q[k].valid <= 1'b0;
    end else if (adv) begin
      side_q[0] <= side_c;
      for (int k = 1; k < DIV_LAT; k++) side_q[k] <= side_q[k-1];
    end
  end

  // hue wrap and output saturation
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      v[k] = side_q[DIV_LAT-1].ctl[k].use_div ? F_W'(res[k].quo)
                                              : F_W'(side_q[DIV_LAT-1].ctl[k].direct);
      if (side_q[DIV_LAT-1].ctl[k].hue_fix && v[k] < 0) v[k] = v[k] + F_W'(rcs_pkg::ONE);
      lane_ovf[k] = side_q[DIV_LAT-1].ctl[k].sat_max ||
                    (side_q[DIV_LAT-1].ctl[k].use_div && res[k].ovf);
      if (v[k] > F_W'(rcs_pkg::OUT_MAX)) begin
        val[k]      = rcs_pkg::OUT_MAX;
        lane_ovf[k] = 1'b1;
      end else if (v[k] < F_W'(rcs_pkg::OUT_MIN)) begin
        val[k]      = rcs_pkg::OUT_MIN;
        lane_ovf[k] = 1'b1;
      end else begin
        val[k] = v[k][OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= side_q[DIV_LAT-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      first_out     <= val[0];
      second_out    <= val[1];
      third_out     <= val[2];
      hue_undefined <= side_q[DIV_LAT-1].hue_undef;
      overflowed    <= |lane_ovf;
    end
  end

  a_hue_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && hue_undefined |-> first_out == '0 && second_out == '0)
    else $error("undefined hue with non-zero hue or saturation");

  a_ovf_extreme: assert property (@(posedge clk) disable iff (rst)
    result_valid && overflowed |->
      first_out == rcs_pkg::OUT_MAX || first_out == rcs_pkg::OUT_MIN ||
      second_out == rcs_pkg::OUT_MAX || second_out == rcs_pkg::OUT_MIN ||
      third_out == rcs_pkg::OUT_MAX || third_out == rcs_pkg::OUT_MIN)
    else $error("overflow flag without a saturated component");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !pixel_ready |=> $stable(side_q[DIV_LAT-1]))
    else $error("pipeline moved during a stall");

endmodule

FILE: tb/sv/rgb_to_color_space_tb.sv
`timescale 1ns / 1ps
module rgb_to_color_space_tb;

  localparam int IN_W  = rcs_pkg::IN_W;
  localparam int OUT_W = rcs_pkg::OUT_W;
  localparam int DRAIN_CYCLES = 30;
  localparam int STALL_LIMIT  = 5000;
  localparam longint MILLION  = 1000000;
  localparam longint UNIT     = 1 << rcs_pkg::FRAC_BITS;

  localparam longint XYZ_M [0:2][0:2] = '{
    '{412453, 357580, 180423},
    '{212671, 715160, 72169},
    '{19334, 119193, 950227}
  };
  localparam longint YIQ_M [0:2][0:2] = '{
    '{299000, 587000, 114000},
    '{596000, -275000, -321000},
    '{212000, -523000, 311000}
  };

  typedef struct {
    logic signed [OUT_W-1:0] first;
    logic signed [OUT_W-1:0] second;
    logic signed [OUT_W-1:0] third;
    logic                    hue_undef;
    logic                    ovf;
  } color_res_t;

  class colour_scoreboard;
    logic [2:0] space;
    color_res_t pending[$];
    int mismatches;
    int pixels_seen;
    int results_seen;
    bit sat_hit;

    function new();
      space = rcs_pkg::SPACE_RGB;
      mismatches = 0;
      pixels_seen = 0;
      results_seen = 0;
    endfunction

    function longint round_div(longint n, longint d);
      longint a, b, q;
      if (d == 0) return 0;
      if (d < 0) begin
        n = -n;
        d = -d;
      end
      a = 2 * n + d;
      b = 2 * d;
      q = a / b;
      if (a % b != 0 && a < 0) q--;
      return q;
    endfunction

    function logic signed [OUT_W-1:0] clamp18(longint v);
      if (v > 131071) begin
        sat_hit = 1;
        return rcs_pkg::OUT_MAX;
      end
      if (v < -131072) begin
        sat_hit = 1;
        return rcs_pkg::OUT_MIN;
      end
      return v[OUT_W-1:0];
    endfunction

    function longint hue_from(longint c[3], longint mx, longint d);
      longint off, diff, h;
      if (c[0] == mx) begin
        off = 0;
        diff = c[1] - c[2];
      end else if (c[1] == mx) begin
        off = 2;
        diff = c[2] - c[0];
      end else begin
        off = 4;
        diff = c[0] - c[1];
      end
      h = round_div((off * d + diff) * UNIT, 6 * d);
      if (h < 0) h += UNIT;
      return h;
    endfunction

    function void note_pixel(logic signed [IN_W-1:0] r, logic signed [IN_W-1:0] g,
                             logic signed [IN_W-1:0] b);
      longint c[3], res[3], t[3], mx, mn, d, s, den, sum;
      bit hu;
      color_res_t e;
      c[0] = r; c[1] = g; c[2] = b;
      res[0] = 0; res[1] = 0; res[2] = 0;
      hu = 0;
      mx = c[0] > c[1] ? c[0] : c[1];
      if (c[2] > mx) mx = c[2];
      mn = c[0] < c[1] ? c[0] : c[1];
      if (c[2] < mn) mn = c[2];
      d = mx - mn;
      case (space)
        rcs_pkg::SPACE_RGB: begin
          res = c;
        end
        rcs_pkg::SPACE_HSL: begin
          s = mx + mn;
          res[2] = round_div(s, 2);
          if (d == 0) hu = 1;
          else begin
            den = (s < UNIT) ? s : 2 * UNIT - s;
            res[1] = (den == 0) ? 131072 : round_div(d * UNIT, den);
            res[0] = hue_from(c, mx, d);
          end
        end
        rcs_pkg::SPACE_HSV: begin
          res[2] = mx;
          if (mx == 0 || d == 0) hu = 1;
          else begin
            res[1] = round_div(d * UNIT, mx);
            res[0] = hue_from(c, mx, d);
          end
        end
        rcs_pkg::SPACE_XYZ, rcs_pkg::SPACE_YIQ: begin
          for (int k = 0; k < 3; k++) begin
            if (space == rcs_pkg::SPACE_XYZ)
              t[k] = XYZ_M[k][0] * c[0] + XYZ_M[k][1] * c[1] + XYZ_M[k][2] * c[2];
            else
              t[k] = YIQ_M[k][0] * c[0] + YIQ_M[k][1] * c[1] + YIQ_M[k][2] * c[2];
            res[k] = round_div(t[k], MILLION);
          end
        end
        rcs_pkg::SPACE_XYY: begin
          for (int k = 0; k < 3; k++)
            t[k] = XYZ_M[k][0] * c[0] + XYZ_M[k][1] * c[1] + XYZ_M[k][2] * c[2];
          sum = t[0] + t[1] + t[2];
          if (sum != 0) begin
            res[0] = round_div(t[0] * UNIT, sum);
            res[1] = round_div(t[1] * UNIT, sum);
            res[2] = round_div(t[1], MILLION);
          end
        end
        default: ;
      endcase
      sat_hit = 0;
      e.first = clamp18(res[0]);
      e.second = clamp18(res[1]);
      e.third = clamp18(res[2]);
      e.hue_undef = hu;
      e.ovf = sat_hit;
      pending.push_back(e);
      pixels_seen++;
    endfunction

    function void check_result(color_res_t got);
      color_res_t e;
      results_seen++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result %0d %0d %0d hu=%0b ovf=%0b", got.first, got.second,
                   got.third, got.hue_undef, got.ovf);
        return;
      end
      e = pending.pop_front();
      if (got.first !== e.first || got.second !== e.second || got.third !== e.third ||
          got.hue_undef !== e.hue_undef || got.ovf !== e.ovf) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch at result %0d: expected %0d %0d %0d hu=%0b ovf=%0b, ",
                    "got %0d %0d %0d hu=%0b ovf=%0b"},
                   results_seen, e.first, e.second, e.third, e.hue_undef, e.ovf,
                   got.first, got.second, got.third, got.hue_undef, got.ovf);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [2:0] cfg_data = '0;
  logic pixel_valid = 0;
  logic pixel_ready;
  logic signed [IN_W-1:0] red = '0, green = '0, blue = '0;
  logic result_valid;
  logic result_ready = 0;
  logic signed [OUT_W-1:0] first_out, second_out, third_out;
  logic hue_undefined, overflowed;

  colour_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;
  bit [7:0] modes_used = '0;

  always #5 clk = ~clk;

  rgb_to_color_space u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .pixel_valid(pixel_valid), .pixel_ready(pixel_ready),
    .red(red), .green(green), .blue(blue),
    .result_valid(result_valid), .result_ready(result_ready),
    .first_out(first_out), .second_out(second_out), .third_out(third_out),
    .hue_undefined(hue_undefined), .overflowed(overflowed)
  );

  always @(posedge clk) begin
    color_res_t got;
    if (!rst) result_ready <= ($urandom_range(99) >= recv_stall_pct);
    if (!rst && result_valid && result_ready) begin
      got.first = first_out;
      got.second = second_out;
      got.third = third_out;
      got.hue_undef = hue_undefined;
      got.ovf = overflowed;
      sb.check_result(got);
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (pixel_valid && pixel_ready) || (result_valid && result_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("** rgb_to_color_space: FAILED **");
      $finish;
    end
  end

  task automatic send_pixel(logic signed [IN_W-1:0] r, logic signed [IN_W-1:0] g,
                            logic signed [IN_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      pixel_valid <= 0;
      @(posedge clk);
    end
    pixel_valid <= 1;
    red <= r;
    green <= g;
    blue <= b;
    // ready is steady between edges, so look at it on the falling edge
    @(negedge clk);
    while (!pixel_ready) @(negedge clk);
    @(posedge clk);
    sb.note_pixel(r, g, b);
  endtask

  task automatic drain();
    pixel_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_space(logic [2:0] v);
    drain();
    cfg_we <= 1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.space = v;
    modes_used[v] = 1;
  endtask

  task automatic send_directed();
    send_pixel(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_pixel(-16'sh8000, -16'sh8000, -16'sh8000);
    send_pixel(16'sh7fff, -16'sh8000, 16'sh0000);
    send_pixel(-16'sh8000, 16'sh7fff, -16'sh8000);
    send_pixel(16'sh0000, -16'sh8000, 16'sh7fff);
    send_pixel(0, 0, 0);
    send_pixel(16'sd4096, 16'sd4096, 16'sd4096);
    send_pixel(16'sd1000, -16'sd1000, 16'sd0);
    send_pixel(16'sd6000, 16'sd2192, 16'sd4000);
    send_pixel(-16'sd500, -16'sd100, -16'sd300);
    send_pixel(16'sd4096, 16'sd4096, 16'sd0);
    send_pixel(16'sd0, 16'sd4096, 16'sd4096);
    send_pixel(16'sd4096, 16'sd0, 16'sd4096);
    send_pixel(16'sd4096, 16'sd0, 16'sd0);
    send_pixel(16'sd0, 16'sd2048, 16'sd4096);
    send_pixel(16'sd1, 16'sd0, 16'sd0);
    send_pixel(-16'sd1, -16'sd1, -16'sd1);
    send_pixel(16'sd3000, 16'sd1000, 16'sd3000);
  endtask

  task automatic send_random();
    logic signed [IN_W-1:0] c[3];
    int kind;
    kind = $urandom_range(5);
    for (int k = 0; k < 3; k++) begin
      case (kind)
        0, 1: c[k] = IN_W'($urandom);
        2, 3: c[k] = IN_W'($urandom_range(4096));
        default: c[k] = IN_W'($signed($urandom_range(8192)) - 4096);
      endcase
    end
    if ($urandom_range(9) == 0) c[1] = c[0];
    if ($urandom_range(9) == 0) c[2] = ($urandom_range(1) == 0) ? c[0] : c[1];
    send_pixel(c[0], c[1], c[2]);
  endtask

  initial begin
    logic [2:0] mode;
    red <= '0;
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    for (int m = 0; m < 8; m++) begin
      set_space(m[2:0]);
      send_directed();
    end

    for (int ph = 0; ph < 16; ph++) begin
      mode = (ph < 8) ? 3'(ph) : 3'($urandom_range(7));
      set_space(mode);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      for (int i = 0; i < 85; i++) begin
        if (i == 40) drain();
        send_random();
      end
    end

    drain();
    $display("covered %0d pixels and %0d results over colour space codes %b",
             sb.pixels_seen, sb.results_seen, modes_used);
    $display("varied sender gaps and receiver stalls, %0d mismatches", sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("** rgb_to_color_space: PASSED **");
    else
      $display("** rgb_to_color_space: FAILED **");
    $finish;
  end
endmodule
